>>> hdl/ubxp_pkg.sv
// Shared constants, codes and structures of the UBX frame parser.
package ubxp_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);

  localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND = 8'h62;
  localparam logic [15:0] RELOAD_RST  = 16'd1000;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic REG_INHIBIT = 1'b0;
  localparam logic REG_RELOAD  = 1'b1;

  typedef enum logic [3:0] {
    PH_SYNC0 = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_CLASS = 4'd2,
    PH_ID    = 4'd3,
    PH_LEN0  = 4'd4,
    PH_LEN1  = 4'd5,
    PH_DATA  = 4'd6,
    PH_CKA   = 4'd7,
    PH_CKB   = 4'd8
  } phase_t;

  typedef struct packed {
    logic        inhibit;
    logic [15:0] timeout_reload;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       msg_class;
    logic [7:0]       msg_id;
    logic [LEN_W-1:0] len;
  } frame_res_t;

endpackage

>>> hdl/ubxp_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface ubxp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_value;
  logic [7:0] read_index;

  modport source (output valid, op, byte_value, read_index, input ready);
  modport sink (input valid, op, byte_value, read_index, output ready);
endinterface

interface ubxp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] msg_class;
  logic [7:0] msg_id;
  logic [8:0] payload_length;
  logic [7:0] read_data;

  modport source (output valid, kind, msg_class, msg_id, payload_length, read_data,
                  input ready);
  modport sink (input valid, kind, msg_class, msg_id, payload_length, read_data,
                output ready);
endinterface

>>> hdl/ubxp_regs.sv
// APB configuration registers: inhibit and timeout reload.
module ubxp_regs
  import ubxp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic        inhibit_r;
  logic [15:0] reload_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inhibit_r <= 1'b0;
      reload_r  <= RELOAD_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_INHIBIT: inhibit_r <= pwdata[0];
        REG_RELOAD:  reload_r  <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INHIBIT: prdata = {31'd0, inhibit_r};
      REG_RELOAD:  prdata = {16'd0, reload_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.inhibit        = inhibit_r;
  assign cfg.timeout_reload = reload_r;

endmodule

>>> hdl/ubxp_store.sv
// Payload buffer: one write port, one read port with registered read data.
module ubxp_store
  import ubxp_pkg::*;
(
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/ubxp_ctrl.sv
// Frame parser state machine, checksum, timeout and buffer write control.
module ubxp_ctrl
  import ubxp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [1:0] op,
  input  logic [7:0] byte_value,
  input  cfg_t       cfg,
  output store_wr_t  wr,
  output frame_res_t res
);

  phase_t           phase_r, phase_nxt;
  logic [15:0]      tcount_r, tcount_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       rsa_r, rsa_nxt;

  logic             byte_ev;
  logic             tick_ev;
  logic             restart;
  logic [7:0]       add_a;
  logic [7:0]       add_b;
  logic [15:0]      len_full;
  logic [LEN_W-1:0] fill_inc;
  logic [15:0]      tcount_dec;

  assign byte_ev    = acc && (op == OP_BYTE) && !cfg.inhibit;
  assign tick_ev    = acc && (op == OP_TICK);
  assign add_a      = sum_a_r + byte_value;
  assign add_b      = sum_b_r + add_a;
  assign len_full   = {byte_value, flen_r[7:0]};
  assign fill_inc   = fill_r + 1'b1;
  assign tcount_dec = tcount_r - 16'd1;

  // An oversized length or an expired timeout mid-frame abandons the frame.
  assign restart = (byte_ev && (phase_r == PH_LEN1) && (len_full > 16'(DEPTH))) ||
                   (tick_ev && (tcount_dec == 16'd0) && (phase_r != PH_SYNC0));

  always_comb begin
    phase_nxt = phase_r;
    if (restart) begin
      phase_nxt = PH_SYNC0;
    end else if (byte_ev) begin
      unique case (phase_r)
        PH_SYNC0: if (byte_value == SYNC_FIRST) phase_nxt = PH_SYNC1;
        PH_SYNC1: if (byte_value == SYNC_SECOND) phase_nxt = PH_CLASS;
        PH_CLASS: phase_nxt = PH_ID;
        PH_ID:    phase_nxt = PH_LEN0;
        PH_LEN0:  phase_nxt = PH_LEN1;
        PH_LEN1:  phase_nxt = (len_full == 16'd0) ? PH_CKA : PH_DATA;
        PH_DATA:  if (fill_inc >= flen_r) phase_nxt = PH_CKA;
        PH_CKA:   phase_nxt = PH_CKB;
        PH_CKB:   phase_nxt = PH_SYNC0;
        default:  phase_nxt = PH_SYNC0;
      endcase
    end
  end

  always_comb begin
    tcount_nxt = tcount_r;
    flen_nxt   = flen_r;
    fill_nxt   = fill_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    rsa_nxt    = rsa_r;
    wr         = '0;
    res        = '0;
    if (tick_ev) begin
      tcount_nxt = tcount_dec;
    end
    if (byte_ev) begin
      unique case (phase_r)
        PH_SYNC0: begin
          if (byte_value == SYNC_FIRST) tcount_nxt = cfg.timeout_reload;
        end
        PH_SYNC1: begin
          if (byte_value == SYNC_SECOND) begin
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end
        end
        PH_CLASS: begin
          class_nxt = byte_value;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
        end
        PH_ID: begin
          id_nxt    = byte_value;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
        end
        PH_LEN0: begin
          flen_nxt  = {1'b0, byte_value};
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
        end
        PH_LEN1: begin
          flen_nxt  = len_full[LEN_W-1:0];
          fill_nxt  = '0;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
        end
        PH_DATA: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          fill_nxt  = fill_inc;
          wr.en     = (fill_r < LEN_W'(DEPTH));
          wr.addr   = fill_r[ADDR_W-1:0];
          wr.data   = byte_value;
        end
        PH_CKA: begin
          rsa_nxt = byte_value;
        end
        PH_CKB: begin
          res.valid     = (rsa_r == sum_a_r) && (byte_value == sum_b_r);
          res.msg_class = class_r;
          res.msg_id    = id_r;
          res.len       = flen_r;
        end
        default: ;
      endcase
    end
    if (restart) begin
      tcount_nxt = cfg.timeout_reload;
      flen_nxt   = '0;
      fill_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC0;
      tcount_r <= RELOAD_RST;
      flen_r   <= '0;
      fill_r   <= '0;
      class_r  <= '0;
      id_r     <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      rsa_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      tcount_r <= tcount_nxt;
      flen_r   <= flen_nxt;
      fill_r   <= fill_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      rsa_r    <= rsa_nxt;
    end
  end

endmodule

>>> hdl/ubx_frame_parser_unit.sv
// Top level of the UBX frame parser: channels, result pipeline and checks.
//
//   port group   direction  contents
//   in_ch        sink       op, byte_value, read_index
//   out_ch       source     kind, msg_class, msg_id, payload_length, read_data
//   APB (p*)     slave      inhibit at 0x0, timeout_reload at 0x4
//
// One transaction is accepted per cycle while the result path moves.
// A result passes from its transaction through the middle stage, alongside the
// registered read of the payload buffer, and then through the output register.
// rst_n is synchronous; the payload buffer is not cleared and needs no sweep.
// A stall on out_ch holds the output register and the stage before it;
// in_ch.ready drops only when both are full and out_ch.ready is low.
module ubx_frame_parser_unit
  import ubxp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ubxp_in_if.sink     in_ch,
  ubxp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  store_wr_t  st_wr;
  frame_res_t res;
  logic [7:0] st_rdata;
  logic       in_acc;
  logic       rd_req;
  logic       s1_adv;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_kind_r;
  logic [7:0]       s1_class_r;
  logic [7:0]       s1_id_r;
  logic [LEN_W-1:0] s1_len_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r;
  logic [7:0]       out_class_r;
  logic [7:0]       out_id_r;
  logic [LEN_W-1:0] out_len_r;
  logic [7:0]       out_rdata_r;

  ubxp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ubxp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .op         (in_ch.op),
    .byte_value (in_ch.byte_value),
    .cfg        (cfg),
    .wr         (st_wr),
    .res        (res)
  );

  ubxp_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_en   (rd_req),
    .rd_addr (in_ch.read_index[ADDR_W-1:0]),
    .rd_data (st_rdata)
  );

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rd_req      = in_acc && (in_ch.op == OP_READ);

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_adv;
    if (in_acc && (res.valid || rd_req)) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (res.valid || rd_req)) begin
      s1_kind_r  <= rd_req ? KIND_READ : KIND_FRAME;
      s1_class_r <= rd_req ? 8'd0 : res.msg_class;
      s1_id_r    <= rd_req ? 8'd0 : res.msg_id;
      s1_len_r   <= rd_req ? '0 : res.len;
    end
    if (s1_valid_r && s1_adv) begin
      out_kind_r  <= s1_kind_r;
      out_class_r <= s1_class_r;
      out_id_r    <= s1_id_r;
      out_len_r   <= s1_len_r;
      out_rdata_r <= (s1_kind_r == KIND_READ) ? st_rdata : 8'd0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = out_kind_r;
  assign out_ch.msg_class      = out_class_r;
  assign out_ch.msg_id         = out_id_r;
  assign out_ch.payload_length = out_len_r;
  assign out_ch.read_data      = out_rdata_r;

`ifndef NO_ASSERTIONS
  // Input is held off only when both result stages are occupied.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free result stage");

  // A waiting result in the middle stage is never dropped.
  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("stalled result lost from middle stage");

  // A completed frame never reports more payload than the buffer holds.
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_FRAME)) |-> (out_len_r <= LEN_W'(DEPTH)))
    else $error("frame result length exceeds buffer");

  // The buffer is written only by an accepted received byte.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr.en |-> (in_acc && (in_ch.op == OP_BYTE) && !cfg.inhibit))
    else $error("buffer write without an accepted byte");
`endif

endmodule
